FILE: rtl/core/hdlc_bit_destuff_crc32_deframer_unit_assert.svh
// assertion macros shared by the deframer rtl
`ifndef HDLC_BIT_DESTUFF_CRC32_DEFRAMER_UNIT_ASSERT_SVH
`define HDLC_BIT_DESTUFF_CRC32_DEFRAMER_UNIT_ASSERT_SVH

// condition and consequence in the same cycle
`define HDLCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define HDLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/hdlcd_pkg.sv
// shared types, constants and the crc byte update for the hdlc deframer
package hdlcd_pkg;

  localparam int          MAX_PAYLOAD_DEF = 32;
  localparam int          LEN_W           = 6;
  localparam int          BYTE_W          = 8;
  localparam int          IDX_W           = 5;
  localparam int          STATUS_W        = 3;
  localparam int          LAG_DEPTH       = 8;
  localparam int          RUN_LIMIT       = 5;
  localparam int          CRC_BYTES       = 4;
  localparam int          LEN_LIMIT       = (1 << LEN_W) - 1;
  localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(12);
  localparam logic [BYTE_W-1:0] FLAG_PAT  = 8'h7E;
  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;

  // frame status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_OPEN  = 3'd1,
    ST_NO_CLOSE = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_STUFF    = 3'd4,
    ST_SHORT    = 3'd5,
    ST_CRC      = 3'd6
  } status_t;

  // payload byte write from the bit engine
  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] data;
  } store_t;

  // reflected crc-32 over one byte, lsb first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                             input logic [BYTE_W-1:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/hdlcd_ram.sv
// generic single write port, single read port ram with registered read
module hdlcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/hdlcd_bit_engine.sv
// one bit per step: flag hunt, 8-bit lag, zero-bit destuffer, byte assembly and crc
module hdlcd_bit_engine import hdlcd_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  localparam int MAX_LEN = (MAX_PAYLOAD < LEN_LIMIT) ? MAX_PAYLOAD : LEN_LIMIT,
  localparam int BCNT_W  = $clog2((MAX_LEN + CRC_BYTES) * BYTE_W + 1),
  localparam int BIDX_W  = BCNT_W - 3,
  localparam int ADDR_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              bit_in,
  input  logic              clr,
  input  logic [LEN_W-1:0]  len,
  output store_t            store,
  output logic [ADDR_W-1:0] store_addr,
  output status_t           status
);

  typedef enum logic [2:0] {
    PH_SEEK   = 3'b001,
    PH_IN     = 3'b010,
    PH_CLOSED = 3'b100
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [BYTE_W-1:0]   flag_r, flag_nxt;
  logic [BYTE_W-1:0]   lag_r, lag_nxt;
  logic [3:0]          lag_cnt_r, lag_cnt_nxt;
  logic [2:0]          ones_r, ones_nxt;
  logic [BCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]   asm_r, asm_nxt;
  logic [31:0]         crc_r, crc_nxt;
  logic [31:0]         crc_rx_r, crc_rx_nxt;
  logic                err_r, err_nxt;

  logic [BYTE_W-1:0]   fs;
  logic                dbit;
  logic [BCNT_W-1:0]   cnt_inc;
  logic [BIDX_W-1:0]   idx;
  logic [BYTE_W-1:0]   asm_new;
  logic [BCNT_W-1:0]   want;

  // bits expected in the frame: payload plus crc bytes
  assign want    = BCNT_W'({(LEN_W + 1)'(len) + (LEN_W + 1)'(CRC_BYTES), 3'b000});
  assign fs      = {flag_r[BYTE_W-2:0], bit_in};
  assign dbit    = lag_r[BYTE_W-1];
  assign cnt_inc = cnt_r + BCNT_W'(1);
  assign idx     = cnt_inc[BCNT_W-1:3] - BIDX_W'(1);
  assign asm_new = {asm_r[BYTE_W-2:0], dbit};

  // next state of one bit step
  always_comb begin
    phase_nxt   = phase_r;
    flag_nxt    = flag_r;
    lag_nxt     = lag_r;
    lag_cnt_nxt = lag_cnt_r;
    ones_nxt    = ones_r;
    cnt_nxt     = cnt_r;
    asm_nxt     = asm_r;
    crc_nxt     = crc_r;
    crc_rx_nxt  = crc_rx_r;
    err_nxt     = err_r;
    store       = '0;
    store_addr  = '0;
    if (clr) begin
      phase_nxt   = PH_SEEK;
      flag_nxt    = '0;
      lag_nxt     = '0;
      lag_cnt_nxt = '0;
      ones_nxt    = '0;
      cnt_nxt     = '0;
      asm_nxt     = '0;
      crc_nxt     = CRC_INIT;
      crc_rx_nxt  = '0;
      err_nxt     = 1'b0;
    end else if (step) begin
      case (phase_r)
        PH_SEEK: begin
          if (fs == FLAG_PAT) begin
            phase_nxt = PH_IN;
            flag_nxt  = '0;
          end else begin
            flag_nxt = fs;
          end
        end
        PH_IN: begin
          flag_nxt = fs;
          if (lag_cnt_r == 4'(LAG_DEPTH)) begin
            // destuffer sees the bit leaving the lag
            if (!err_r && (cnt_r < want)) begin
              if (ones_r == 3'(RUN_LIMIT)) begin
                if (dbit) begin
                  err_nxt = 1'b1;
                end else begin
                  ones_nxt = '0;
                end
              end else begin
                asm_nxt  = asm_new;
                cnt_nxt  = cnt_inc;
                ones_nxt = dbit ? (ones_r + 3'd1) : 3'd0;
                if (cnt_inc[2:0] == 3'd0) begin
                  if ((LEN_W + 1)'(idx) < (LEN_W + 1)'(len)) begin
                    store.en   = 1'b1;
                    store.data = asm_new;
                    store_addr = ADDR_W'(idx);
                    crc_nxt    = crc32_byte(crc_r, asm_new);
                  end else begin
                    crc_rx_nxt = {asm_new, crc_rx_r[31:BYTE_W]};
                  end
                end
              end
            end
          end else begin
            lag_cnt_nxt = lag_cnt_r + 4'd1;
          end
          lag_nxt = {lag_r[BYTE_W-2:0], bit_in};
          if (fs == FLAG_PAT) begin
            phase_nxt = PH_CLOSED;
          end
        end
        PH_CLOSED: begin
        end
        default: begin
          phase_nxt = PH_SEEK;
        end
      endcase
    end
  end

  // frame verdict from the current state
  always_comb begin
    if (len == '0) begin
      status = ST_SHORT;
    end else if (phase_r == PH_SEEK) begin
      status = ST_NO_OPEN;
    end else if (phase_r == PH_IN) begin
      status = ST_NO_CLOSE;
    end else if (cnt_r == '0) begin
      status = ST_EMPTY;
    end else if (err_r) begin
      status = ST_STUFF;
    end else if (cnt_r < want) begin
      status = ST_SHORT;
    end else if (~crc_r != crc_rx_r) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SEEK;
      flag_r    <= '0;
      lag_r     <= '0;
      lag_cnt_r <= '0;
      ones_r    <= '0;
      cnt_r     <= '0;
      asm_r     <= '0;
      crc_r     <= CRC_INIT;
      crc_rx_r  <= '0;
      err_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      flag_r    <= flag_nxt;
      lag_r     <= lag_nxt;
      lag_cnt_r <= lag_cnt_nxt;
      ones_r    <= ones_nxt;
      cnt_r     <= cnt_nxt;
      asm_r     <= asm_nxt;
      crc_r     <= crc_nxt;
      crc_rx_r  <= crc_rx_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

FILE: rtl/core/hdlc_bit_destuff_crc32_deframer_unit.sv
// top level of the hdlc deframer: input sequencer, payload ram, result output
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   in       | in_valid / in_ready     | in_rx_byte, in_last_byte
//   out      | out_valid / out_ready   | out_payload_byte, out_byte_index,
//            |                         | out_status, out_last_result
//   cfg      | cfg_wr_en               | cfg_wr_data (payload length)
//
// each input beat has an accept cycle, then 8 bit steps through the shared engine
// a last beat adds a verdict step; each payload result then goes through ram read, output load
// and handoff, which an out stall can hold; an error gives a single result
// rst_n is synchronous; the payload ram needs no clearing pass
// in_ready is high only while the sequencer is idle and no result is pending
`include "hdlc_bit_destuff_crc32_deframer_unit_assert.svh"

module hdlc_bit_destuff_crc32_deframer_unit import hdlcd_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   in_rx_byte,
  input  logic                in_last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BYTE_W-1:0]   out_payload_byte,
  output logic [IDX_W-1:0]    out_byte_index,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_last_result,
  input  logic                cfg_wr_en,
  input  logic [LEN_W-1:0]    cfg_wr_data
);

  localparam int MAX_LEN = (MAX_PAYLOAD < LEN_LIMIT) ? MAX_PAYLOAD : LEN_LIMIT;
  localparam int ADDR_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [2:0] BIT_LAST = 3'(BYTE_W - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_BITS   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_RD     = 6'b001000,
    S_LOAD   = 6'b010000,
    S_WAIT   = 6'b100000
  } seq_t;

  seq_t                state_r, state_nxt;
  logic [LEN_W-1:0]    len_r;
  logic [LEN_W-1:0]    len_eff;
  logic [BYTE_W-1:0]   shreg_r, shreg_nxt;
  logic                last_r, last_nxt;
  logic [2:0]          bit_cnt_r, bit_cnt_nxt;
  logic [LEN_W-1:0]    emit_idx_r, emit_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  logic                eng_step;
  logic                eng_clr;
  store_t              eng_store;
  logic [ADDR_W-1:0]   eng_addr;
  status_t             eng_status;
  logic                rd_en;
  logic [BYTE_W-1:0]   rd_data;
  logic                emit_is_last;

  // payload length register, saturated on use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (cfg_wr_en) begin
      len_r <= cfg_wr_data;
    end
  end

  assign len_eff = (len_r > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_r;

  // shared bit engine
  hdlcd_bit_engine #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (eng_step),
    .bit_in     (shreg_r[BYTE_W-1]),
    .clr        (eng_clr),
    .len        (len_eff),
    .store      (eng_store),
    .store_addr (eng_addr),
    .status     (eng_status)
  );

  // payload store
  hdlcd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (eng_store.en),
    .wr_addr (eng_addr),
    .wr_data (eng_store.data),
    .rd_en   (rd_en),
    .rd_addr (ADDR_W'(emit_idx_r)),
    .rd_data (rd_data)
  );

  assign emit_is_last = (({1'b0, emit_idx_r} + (LEN_W + 1)'(1)) == {1'b0, len_eff});

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    shreg_nxt      = shreg_r;
    last_nxt       = last_r;
    bit_cnt_nxt    = bit_cnt_r;
    emit_idx_nxt   = emit_idx_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_idx_nxt    = out_idx_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    eng_step       = 1'b0;
    eng_clr        = 1'b0;
    rd_en          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          shreg_nxt   = in_rx_byte;
          last_nxt    = in_last_byte;
          bit_cnt_nxt = '0;
          state_nxt   = S_BITS;
        end
      end
      S_BITS: begin
        eng_step    = 1'b1;
        shreg_nxt   = {shreg_r[BYTE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == BIT_LAST) begin
          state_nxt = last_r ? S_DECIDE : S_IDLE;
        end
      end
      S_DECIDE: begin
        if (eng_status != ST_OK) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = '0;
          out_idx_nxt    = '0;
          out_status_nxt = eng_status;
          out_last_nxt   = 1'b1;
          state_nxt      = S_WAIT;
        end else begin
          emit_idx_nxt = '0;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        out_valid_nxt  = 1'b1;
        out_byte_nxt   = rd_data;
        out_idx_nxt    = emit_idx_r[IDX_W-1:0];
        out_status_nxt = ST_OK;
        out_last_nxt   = emit_is_last;
        state_nxt      = S_WAIT;
      end
      S_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            eng_clr   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + LEN_W'(1);
            state_nxt    = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_cnt_r   <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    shreg_r      <= shreg_nxt;
    out_byte_r   <= out_byte_nxt;
    out_idx_r    <= out_idx_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_index   = out_idx_r;
  assign out_status       = out_status_r;
  assign out_last_result  = out_last_r;

  // checks
  `HDLCD_ASSERT_SAME(a_ready_no_pending, in_ready, !out_valid, "input ready while a result waits")
  `HDLCD_ASSERT_NEXT(a_accept_starts_bits, in_valid && in_ready, state_r == S_BITS, "accepted beat did not start bit steps")
  `HDLCD_ASSERT_SAME(a_error_is_last, out_valid && (out_status_r != ST_OK), out_last_result, "error result not marked last")
  `HDLCD_ASSERT_NEXT(a_bits_end, (state_r == S_BITS) && (bit_cnt_r == BIT_LAST), state_r != S_BITS, "bit steps ran past one byte")

endmodule
